>>> hdl/gcja_pkg.sv
package gcja_pkg;

    localparam int MAX_JOBS_DEFAULT = 1024;

    localparam int JOB_COUNT_W = 11;
    localparam int PENALTY_W   = 16;
    localparam int CAP_W       = 16;
    localparam int JOB_W       = 10;
    localparam int SUM_W       = 27;

    localparam logic [JOB_COUNT_W-1:0] JOB_COUNT_RESET = JOB_COUNT_W'(1024);
    localparam logic [JOB_COUNT_W-1:0] COUNT_MAX       = '1;
    localparam logic [SUM_W-1:0]       SUM_MAX         = '1;

    // Map entries hold the epoch in which the job was taken; zero never matches.
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_JOB_COUNT = 1'b0;
    localparam logic REG_PENALTY   = 1'b1;

    typedef struct packed {
        logic             row_start;
        logic [CAP_W-1:0] capacity;
        logic [JOB_W-1:0] job_index;
        logic [CAP_W-1:0] proc_time;
        logic [CAP_W-1:0] cost;
        logic             last_item;
    } job_item_t;

    typedef struct packed {
        logic             assigned;
        logic [CAP_W-1:0] remaining_capacity;
        logic [SUM_W-1:0] total_cost;
        logic             total_valid;
    } result_item_t;

    typedef struct packed {
        logic [JOB_COUNT_W-1:0] job_count;
        logic [PENALTY_W-1:0]   penalty;
    } cfg_t;

    typedef struct packed {
        logic               run;
        logic [EPOCH_W-1:0] epoch;
    } seq_ctl_t;

    typedef struct packed {
        logic last_done;
    } pipe_stat_t;

    typedef enum logic {
        SEQ_CLEAR,
        SEQ_RUN
    } seq_state_t;

endpackage

>>> hdl/greedy_capacity_job_assigner_core.sv
// The item is registered in the decision stage, then in the output register behind res_valid;
// a held output (res_ready low) stalls the decision stage.
// Throughput: one item per cycle while neither res_ready nor a map sweep holds the flow,
// set by the single read-modify-write of the job map memory. After every 255th instance
// the map is swept once, accepting no items. Reset: asynchronous, active low. Counters
// clear at once; the job map is then swept, one entry a cycle, before the first item is accepted.
module greedy_capacity_job_assigner_core #(
    parameter int MAX_JOBS = gcja_pkg::MAX_JOBS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  gcja_pkg::job_item_t          job_item,
    output logic                         res_valid,
    input  logic                         res_ready,
    output gcja_pkg::result_item_t       res_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gcja_pkg::PADDR_W-1:0] paddr,
    input  logic [gcja_pkg::PDATA_W-1:0] pwdata,
    output logic [gcja_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int AW = $clog2(MAX_JOBS);

    gcja_pkg::cfg_t       cfg;
    gcja_pkg::seq_ctl_t   ctl;
    gcja_pkg::pipe_stat_t stat;

    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [gcja_pkg::EPOCH_W-1:0] rd_tag;
    logic                         pipe_wr_en;
    logic [AW-1:0]                pipe_wr_addr;
    logic                         mem_wr_en;
    logic [AW-1:0]                mem_wr_addr;
    logic [gcja_pkg::EPOCH_W-1:0] mem_wr_tag;

    gcja_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gcja_taken_mem #(.MAX_JOBS(MAX_JOBS)) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_tag  (rd_tag),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_tag  (mem_wr_tag)
    );

    gcja_seq #(.MAX_JOBS(MAX_JOBS)) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .stat         (stat),
        .pipe_wr_en   (pipe_wr_en),
        .pipe_wr_addr (pipe_wr_addr),
        .ctl          (ctl),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_tag   (mem_wr_tag)
    );

    gcja_assign_pipe #(.MAX_JOBS(MAX_JOBS)) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_item  (job_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg       (cfg),
        .ctl       (ctl),
        .stat      (stat),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_tag    (rd_tag),
        .wr_en     (pipe_wr_en),
        .wr_addr   (pipe_wr_addr)
    );

endmodule

>>> hdl/gcja_cfg_regs.sv
module gcja_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gcja_pkg::PADDR_W-1:0] paddr,
    input  logic [gcja_pkg::PDATA_W-1:0] pwdata,
    output logic [gcja_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output gcja_pkg::cfg_t              cfg
);

    logic [gcja_pkg::JOB_COUNT_W-1:0] job_count_reg;
    logic [gcja_pkg::PENALTY_W-1:0]   penalty_reg;
    logic                             wr_en;

    // word addressed: the low byte-address bits are not decoded
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_count_reg <= gcja_pkg::JOB_COUNT_RESET;
            penalty_reg   <= '0;
        end
        else if (wr_en)
        begin
            if (paddr[2] == gcja_pkg::REG_JOB_COUNT)
                job_count_reg <= pwdata[gcja_pkg::JOB_COUNT_W-1:0];
            else
                penalty_reg <= pwdata[gcja_pkg::PENALTY_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == gcja_pkg::REG_JOB_COUNT)
            prdata = gcja_pkg::PDATA_W'(job_count_reg);
        else
            prdata = gcja_pkg::PDATA_W'(penalty_reg);
    end

    assign cfg.job_count = job_count_reg;
    assign cfg.penalty   = penalty_reg;

endmodule

>>> hdl/gcja_taken_mem.sv
module gcja_taken_mem #(
    parameter int MAX_JOBS = gcja_pkg::MAX_JOBS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_JOBS)-1:0]  rd_addr,
    output logic [gcja_pkg::EPOCH_W-1:0] rd_tag,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_JOBS)-1:0]  wr_addr,
    input  logic [gcja_pkg::EPOCH_W-1:0] wr_tag
);

    logic [gcja_pkg::EPOCH_W-1:0] mem [MAX_JOBS];
    logic [gcja_pkg::EPOCH_W-1:0] rd_tag_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_tag;
        if (rd_en)
            rd_tag_reg <= mem[rd_addr];
    end

    assign rd_tag = rd_tag_reg;

endmodule

>>> hdl/gcja_seq.sv
module gcja_seq #(
    parameter int MAX_JOBS = gcja_pkg::MAX_JOBS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gcja_pkg::pipe_stat_t         stat,
    input  logic                         pipe_wr_en,
    input  logic [$clog2(MAX_JOBS)-1:0]  pipe_wr_addr,
    output gcja_pkg::seq_ctl_t           ctl,
    output logic                         mem_wr_en,
    output logic [$clog2(MAX_JOBS)-1:0]  mem_wr_addr,
    output logic [gcja_pkg::EPOCH_W-1:0] mem_wr_tag
);

    localparam int AW = $clog2(MAX_JOBS);

    gcja_pkg::seq_state_t         state_reg, state_next;
    logic [AW-1:0]                ptr_reg, ptr_next;
    logic [gcja_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic                         clear_done;
    logic                         wrap;

    assign clear_done = (ptr_reg == AW'(MAX_JOBS - 1));
    assign wrap       = stat.last_done && (epoch_reg == gcja_pkg::EPOCH_LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gcja_pkg::SEQ_CLEAR: if (clear_done) state_next = gcja_pkg::SEQ_RUN;
            gcja_pkg::SEQ_RUN:   if (wrap)       state_next = gcja_pkg::SEQ_CLEAR;
            default:             state_next = gcja_pkg::SEQ_CLEAR;
        endcase
    end

    always_comb
    begin
        ptr_next   = ptr_reg;
        epoch_next = epoch_reg;
        unique case (state_reg)
            gcja_pkg::SEQ_CLEAR:
            begin
                ctl.run     = 1'b0;
                mem_wr_en   = 1'b1;
                mem_wr_addr = ptr_reg;
                mem_wr_tag  = '0;
                ptr_next    = clear_done ? '0 : ptr_reg + AW'(1);
            end
            default:
            begin
                ctl.run     = 1'b1;
                mem_wr_en   = pipe_wr_en;
                mem_wr_addr = pipe_wr_addr;
                mem_wr_tag  = epoch_reg;
                // epoch bump drops every mark of the finished instance
                if (stat.last_done)
                    epoch_next = wrap ? gcja_pkg::EPOCH_FIRST
                                      : epoch_reg + gcja_pkg::EPOCH_W'(1);
            end
        endcase
    end

    assign ctl.epoch = epoch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gcja_pkg::SEQ_CLEAR;
            ptr_reg   <= '0;
            epoch_reg <= gcja_pkg::EPOCH_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            epoch_reg <= epoch_next;
        end
    end

endmodule

>>> hdl/gcja_assign_pipe.sv
module gcja_assign_pipe #(
    parameter int MAX_JOBS = gcja_pkg::MAX_JOBS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  gcja_pkg::job_item_t          job_item,
    output logic                         res_valid,
    input  logic                         res_ready,
    output gcja_pkg::result_item_t       res_item,
    input  gcja_pkg::cfg_t               cfg,
    input  gcja_pkg::seq_ctl_t           ctl,
    output gcja_pkg::pipe_stat_t         stat,
    output logic                         rd_en,
    output logic [$clog2(MAX_JOBS)-1:0]  rd_addr,
    input  logic [gcja_pkg::EPOCH_W-1:0] rd_tag,
    output logic                         wr_en,
    output logic [$clog2(MAX_JOBS)-1:0]  wr_addr
);

    localparam int AW = $clog2(MAX_JOBS);

    // decision stage
    logic                     s1_valid_reg;
    gcja_pkg::job_item_t      s1_item_reg;
    logic [AW-1:0]            s1_addr_reg;
    logic                     s1_in_range_reg;
    logic                     s1_fwd_reg;

    logic [gcja_pkg::CAP_W-1:0]       cap_left_reg;
    logic [gcja_pkg::SUM_W-1:0]       cost_sum_reg;
    logic [gcja_pkg::JOB_COUNT_W-1:0] taken_count_reg;

    logic                   out_valid_reg;
    gcja_pkg::result_item_t out_item_reg;

    logic          s1_fire;
    logic          job_fire;
    logic          wrap_hold;
    logic [AW-1:0] in_addr;
    logic          in_range;

    logic [gcja_pkg::CAP_W-1:0]       cap_cur;
    logic [gcja_pkg::CAP_W-1:0]       cap_new;
    logic                             taken;
    logic                             assign_now;
    logic [gcja_pkg::SUM_W:0]         sum_add;
    logic [gcja_pkg::SUM_W-1:0]       sum_new;
    logic [gcja_pkg::JOB_COUNT_W-1:0] cnt_new;
    logic [gcja_pkg::JOB_COUNT_W-1:0] unassigned;
    logic [gcja_pkg::SUM_W-1:0]       pen_prod;
    logic [gcja_pkg::SUM_W:0]         total_add;
    logic [gcja_pkg::SUM_W-1:0]       total;

    assign in_addr  = AW'(job_item.job_index);
    assign in_range = (32'(job_item.job_index) < MAX_JOBS);

    // a last item that wraps the epoch needs the map swept before anything follows
    assign wrap_hold = s1_valid_reg && s1_item_reg.last_item
                       && (ctl.epoch == gcja_pkg::EPOCH_LAST);
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || res_ready);
    assign job_ready = ctl.run && !wrap_hold && (!s1_valid_reg || s1_fire);
    assign job_fire  = job_valid && job_ready;

    assign rd_en   = job_fire;
    assign rd_addr = in_addr;

    always_comb
    begin
        cap_cur    = s1_item_reg.row_start ? s1_item_reg.capacity : cap_left_reg;
        // forward the write landing on the same edge as this item's read
        taken      = (rd_tag == ctl.epoch) || s1_fwd_reg;
        assign_now = s1_in_range_reg && !taken && (s1_item_reg.proc_time <= cap_cur);
        cap_new    = assign_now ? cap_cur - s1_item_reg.proc_time : cap_cur;

        sum_add = {1'b0, cost_sum_reg} + (gcja_pkg::SUM_W + 1)'(s1_item_reg.cost);
        if (!assign_now)
            sum_new = cost_sum_reg;
        else if (sum_add[gcja_pkg::SUM_W])
            sum_new = gcja_pkg::SUM_MAX;
        else
            sum_new = sum_add[gcja_pkg::SUM_W-1:0];

        if (assign_now && (taken_count_reg != gcja_pkg::COUNT_MAX))
            cnt_new = taken_count_reg + gcja_pkg::JOB_COUNT_W'(1);
        else
            cnt_new = taken_count_reg;

        unassigned = (cfg.job_count > cnt_new) ? cfg.job_count - cnt_new : '0;
        // 11 x 16 bits never exceeds the saturation limit
        pen_prod   = gcja_pkg::SUM_W'(unassigned) * gcja_pkg::SUM_W'(cfg.penalty);
        total_add  = {1'b0, sum_new} + {1'b0, pen_prod};
        total      = total_add[gcja_pkg::SUM_W] ? gcja_pkg::SUM_MAX
                                                 : total_add[gcja_pkg::SUM_W-1:0];
    end

    assign wr_en   = s1_fire && assign_now;
    assign wr_addr = s1_addr_reg;

    assign stat.last_done = s1_fire && s1_item_reg.last_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s1_fwd_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            cap_left_reg    <= '0;
            cost_sum_reg    <= '0;
            taken_count_reg <= '0;
        end
        else
        begin
            if (job_fire)
            begin
                s1_valid_reg <= 1'b1;
                s1_fwd_reg   <= s1_fire && assign_now && !s1_item_reg.last_item
                                && (s1_addr_reg == in_addr);
            end
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                cap_left_reg  <= cap_new;
                if (s1_item_reg.last_item)
                begin
                    cost_sum_reg    <= '0;
                    taken_count_reg <= '0;
                end
                else
                begin
                    cost_sum_reg    <= sum_new;
                    taken_count_reg <= cnt_new;
                end
            end
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_fire)
        begin
            s1_item_reg     <= job_item;
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= in_range;
        end
        if (s1_fire)
        begin
            out_item_reg.assigned           <= assign_now;
            out_item_reg.remaining_capacity <= cap_new;
            out_item_reg.total_cost         <= s1_item_reg.last_item ? total : '0;
            out_item_reg.total_valid        <= s1_item_reg.last_item;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

endmodule
